[hw/rtl/rdma_receiver_ack_nack_tracker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the RDMA receiver ACK/NACK tracker
// Shorthand for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RDMA_RECEIVER_ACK_NACK_TRACKER_ASSERT_SVH
`define RDMA_RECEIVER_ACK_NACK_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RNT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RNT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/rnt_pkg.sv]
// ----------------------------------------------------------------------------
// RDMA receiver tracker package
// Shared types and constants of the controller and datapath.
// ----------------------------------------------------------------------------
package rnt_pkg;

  localparam int unsigned Flows     = 16;
  localparam int unsigned FlowW     = 4;
  localparam int unsigned WindowMax = 16;
  localparam int unsigned WinIdxW   = 4;
  localparam int unsigned WinCntW   = 5;
  localparam int unsigned SlotW     = 48;

  localparam logic [4:0]  WinReset = 5'd16;
  localparam logic [19:0] BwReset  = 20'd25600;

  // Configuration register indexes.
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_BANDWIDTH   = 1'b1;

  // Transaction command codes.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_DUP   = 2'd0,
    ST_INORD = 2'd1,
    ST_OOO   = 2'd2,
    ST_CLEAR = 2'd3
  } pkt_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;
    logic clear;
    logic sample;
    logic scan;
    logic classify;
    logic adv;
    logic absorb;
    logic commit;
    logic div_start;
    logic store;
    logic mul;
    logic cmp;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic        is_clear;
    logic        scan_done;
    pkt_status_e cls;
    logic        absorb_done;
    logic        div_done;
  } dp_status_t;

endpackage

[hw/rtl/rnt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rnt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rnt_div.sv]
// ----------------------------------------------------------------------------
// Dual restoring divider
// Divides two 32-bit dividends by one 16-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rnt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dvd_a_i,
  input  logic [31:0] dvd_b_i,
  input  logic [15:0] dvs_i,
  output logic [31:0] quo_a_o,
  output logic [31:0] quo_b_o,
  output logic        done_o
);

  localparam logic [5:0] Steps = 6'd32;

  logic [31:0] qa_q, qb_q;
  logic [15:0] ra_q, rb_q;
  logic [15:0] d_q;
  logic [5:0]  cnt_q;
  logic        run_q;
  logic [16:0] ta, tb;
  logic        ga, gb;

  // Trial subtraction for both lanes.
  always_comb begin
    ta = {ra_q, qa_q[31]};
    tb = {rb_q, qb_q[31]};
    ga = ta >= {1'b0, d_q};
    gb = tb >= {1'b0, d_q};
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= Steps;
    end else if (run_q) begin
      cnt_q <= cnt_q - 6'd1;
      run_q <= cnt_q != 6'd1;
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qa_q <= dvd_a_i;
      qb_q <= dvd_b_i;
      ra_q <= '0;
      rb_q <= '0;
      d_q  <= dvs_i;
    end else if (run_q) begin
      ra_q <= ga ? 16'(ta - {1'b0, d_q}) : ta[15:0];
      rb_q <= gb ? 16'(tb - {1'b0, d_q}) : tb[15:0];
      qa_q <= {qa_q[30:0], ga};
      qb_q <= {qb_q[30:0], gb};
    end
  end

  assign quo_a_o = qa_q;
  assign quo_b_o = qb_q;
  assign done_o  = !run_q;

endmodule

[hw/rtl/rnt_dp.sv]
// ----------------------------------------------------------------------------
// RDMA receiver tracker datapath
// Per-flow state, delay window scan, reorder slots, divider and NACK test.
// ----------------------------------------------------------------------------
module rnt_dp #(
  parameter int unsigned PendingSlots = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rnt_pkg::ctl_cmd_t   ctl_i,
  output rnt_pkg::dp_status_t stat_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [19:0]         cfg_wdata_i,
  input  logic                cmd_i,
  input  logic [3:0]          flow_i,
  input  logic [31:0]         seq_i,
  input  logic [15:0]         size_i,
  input  logic [15:0]         packet_size_i,
  input  logic [31:0]         delay_ns_i,
  output logic [1:0]          status_o,
  output logic [31:0]         ack_seq_o,
  output logic                nack_o,
  output logic [31:0]         nack_seq_o,
  output logic [15:0]         nack_size_o,
  output logic [31:0]         gap_o,
  output logic [32:0]         rtt_min_o,
  output logic [32:0]         rtt_max_o,
  output logic [31:0]         delay_spread_o,
  output logic                buffer_overflow_o
);
  import rnt_pkg::*;

  localparam int unsigned RowW  = PendingSlots * SlotW;
  localparam int unsigned IterW = $clog2(PendingSlots + 1);
  localparam int unsigned SelW  = (PendingSlots > 1) ? $clog2(PendingSlots) : 1;
  localparam logic [IterW-1:0] IterMax = IterW'(PendingSlots);

  // Captured transaction and configuration.
  logic                    cmd_q;
  logic [FlowW-1:0]        flow_q;
  logic [31:0]             seq_q, delay_q;
  logic [15:0]             size_q, psize_q;
  logic [4:0]              win_q;
  logic [19:0]             bw_q;

  // Per-flow state.
  logic [31:0]             exp_mem_q [Flows];
  logic [WinCntW-1:0]      cnt_q     [Flows];
  logic [WinIdxW-1:0]      head_q    [Flows];
  logic [PendingSlots-1:0] pv_q      [Flows];

  // Working registers.
  logic [31:0]             exp_w_q, lo_q, hi_q, gap_q;
  logic [WinCntW-1:0]      k_q;
  logic                    rdv_q, ovf_q, nack_q;
  logic [IterW-1:0]        iter_q;
  pkt_status_e             class_q;
  logic [47:0]             prod_a_q;
  logic [51:0]             prod_b_q;

  // Memory ports.
  logic                    dly_we, dly_re;
  logic [WinIdxW+FlowW-1:0] dly_waddr, dly_raddr;
  logic [31:0]             dly_rdata;
  logic                    pnd_we;
  logic [RowW-1:0]         pnd_wdata, pnd_rdata;

  // Combinational helpers.
  logic [4:0]              w_eff;
  logic [WinCntW-1:0]      cnt_cur, cnt_inc;
  logic [WinIdxW-1:0]      head_cur, rd_idx;
  logic                    has_win, issue;
  logic [15:0]             step;
  pkt_status_e             cls_c;
  logic [PendingSlots-1:0] pv_cur;
  logic                    hit_any, same_any, free_any;
  logic [SelW-1:0]         hit_sel, same_sel, free_sel, st_sel;
  logic [31:0]             spread, quo_a, quo_b;
  logic                    div_done;

  // Effective window length and sample bookkeeping.
  always_comb begin
    if (win_q == 5'd0) begin
      w_eff = 5'd1;
    end else if (win_q > 5'(WindowMax)) begin
      w_eff = 5'(WindowMax);
    end else begin
      w_eff = win_q;
    end
    cnt_cur  = cnt_q[flow_q];
    head_cur = head_q[flow_q];
    cnt_inc  = (cnt_cur < WinCntW'(WindowMax)) ? cnt_cur + 1'b1 : cnt_cur;
    if (cnt_inc > w_eff) begin
      cnt_inc = w_eff;
    end
    has_win  = cnt_cur >= WinCntW'(2);
    issue    = has_win && (k_q < cnt_cur);
    rd_idx   = head_cur - WinIdxW'(1) - k_q[WinIdxW-1:0];
    step     = (psize_q != 16'd0) ? psize_q : ((size_q > 16'd1) ? size_q : 16'd1);
    spread   = hi_q - lo_q;
  end

  // Classification against the expected sequence.
  always_comb begin
    if (seq_q < exp_w_q) begin
      cls_c = ST_DUP;
    end else if (seq_q == exp_w_q) begin
      cls_c = ST_INORD;
    end else begin
      cls_c = ST_OOO;
    end
  end

  // Slot searches over the flow's pending row, lowest slot first.
  always_comb begin
    pv_cur   = pv_q[flow_q];
    hit_any  = 1'b0;
    same_any = 1'b0;
    free_any = 1'b0;
    hit_sel  = '0;
    same_sel = '0;
    free_sel = '0;
    for (int s = PendingSlots - 1; s >= 0; s--) begin
      if (pv_cur[s] && pnd_rdata[s*SlotW +: 32] == exp_w_q) begin
        hit_any = 1'b1;
        hit_sel = SelW'(s);
      end
      if (pv_cur[s] && pnd_rdata[s*SlotW +: 32] == seq_q) begin
        same_any = 1'b1;
        same_sel = SelW'(s);
      end
      if (!pv_cur[s]) begin
        free_any = 1'b1;
        free_sel = SelW'(s);
      end
    end
    st_sel    = same_any ? same_sel : free_sel;
    pnd_wdata = pnd_rdata;
    pnd_wdata[32'(st_sel)*SlotW +: SlotW] = {size_q, seq_q};
  end

  // Memory port control.
  assign dly_we    = ctl_i.sample && !cmd_q && (delay_q != 32'd0);
  assign dly_waddr = {flow_q, head_cur};
  assign dly_re    = ctl_i.scan && issue;
  assign dly_raddr = {flow_q, rd_idx};
  assign pnd_we    = ctl_i.store && (same_any || free_any);

  rnt_ram #(.Width(32), .Depth(Flows * WindowMax)) u_dly_ram (
    .clk_i,
    .we_i   (dly_we),
    .waddr_i(dly_waddr),
    .wdata_i(delay_q),
    .re_i   (dly_re),
    .raddr_i(dly_raddr),
    .rdata_o(dly_rdata)
  );

  rnt_ram #(.Width(RowW), .Depth(Flows)) u_pnd_ram (
    .clk_i,
    .we_i   (pnd_we),
    .waddr_i(flow_q),
    .wdata_i(pnd_wdata),
    .re_i   (ctl_i.sample),
    .raddr_i(flow_q),
    .rdata_o(pnd_rdata)
  );

  rnt_div u_div (
    .clk_i,
    .rst_ni,
    .start_i(ctl_i.div_start),
    .dvd_a_i(exp_w_q),
    .dvd_b_i(seq_q),
    .dvs_i  (step),
    .quo_a_o(quo_a),
    .quo_b_o(quo_b),
    .done_o (div_done)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WinReset;
      bw_q  <= BwReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW_SIZE: win_q <= cfg_wdata_i[4:0];
        REG_BANDWIDTH:   bw_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-flow control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < Flows; f++) begin
        exp_mem_q[f] <= '0;
        cnt_q[f]     <= '0;
        head_q[f]    <= '0;
        pv_q[f]      <= '0;
      end
    end else begin
      if (ctl_i.clear) begin
        exp_mem_q[flow_q] <= '0;
        cnt_q[flow_q]     <= '0;
        head_q[flow_q]    <= '0;
        pv_q[flow_q]      <= '0;
      end
      if (dly_we) begin
        head_q[flow_q] <= head_cur + WinIdxW'(1);
        cnt_q[flow_q]  <= cnt_inc;
      end
      if (ctl_i.absorb && hit_any && iter_q != IterMax) begin
        pv_q[flow_q][hit_sel] <= 1'b0;
      end
      if (pnd_we) begin
        pv_q[flow_q][st_sel] <= 1'b1;
      end
      if (ctl_i.commit) begin
        exp_mem_q[flow_q] <= exp_w_q;
      end
    end
  end

  // Transaction capture.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap) begin
      cmd_q   <= cmd_i;
      flow_q  <= flow_i;
      seq_q   <= seq_i;
      size_q  <= size_i;
      psize_q <= packet_size_i;
      delay_q <= delay_ns_i;
    end
  end

  // Scan counter and read-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      rdv_q  <= 1'b0;
      iter_q <= '0;
    end else begin
      if (ctl_i.sample) begin
        k_q    <= '0;
        rdv_q  <= 1'b0;
        iter_q <= '0;
      end else if (ctl_i.scan) begin
        rdv_q <= issue;
        if (issue) begin
          k_q <= k_q + 1'b1;
        end
      end
      if (ctl_i.absorb && hit_any && iter_q != IterMax) begin
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      exp_w_q <= '0;
      gap_q   <= '0;
      ovf_q   <= 1'b0;
      nack_q  <= 1'b0;
      class_q <= ST_CLEAR;
    end
    if (ctl_i.sample) begin
      exp_w_q <= exp_mem_q[flow_q];
      lo_q    <= '1;
      hi_q    <= '0;
      gap_q   <= '0;
      ovf_q   <= 1'b0;
      nack_q  <= 1'b0;
    end
    if (ctl_i.scan && rdv_q) begin
      if (dly_rdata < lo_q) begin
        lo_q <= dly_rdata;
      end
      if (dly_rdata > hi_q) begin
        hi_q <= dly_rdata;
      end
    end
    if (ctl_i.classify) begin
      class_q <= cls_c;
    end
    if (ctl_i.adv) begin
      exp_w_q <= exp_w_q + 32'(size_q);
    end
    if (ctl_i.absorb && hit_any && iter_q != IterMax) begin
      exp_w_q <= exp_w_q + 32'(pnd_rdata[32'(hit_sel)*SlotW + 32 +: 16]);
    end
    if (ctl_i.store) begin
      gap_q <= (quo_b > quo_a) ? quo_b - quo_a : 32'd0;
      ovf_q <= !(same_any || free_any);
    end
    if (ctl_i.mul) begin
      prod_a_q <= 48'(gap_q) * 48'(step);
      prod_b_q <= 52'(spread) * 52'(bw_q);
    end
    if (ctl_i.cmp) begin
      nack_q <= has_win && ({prod_a_q, 11'b0} > {7'b0, prod_b_q});
    end
  end

  // Status towards the controller.
  assign stat_o.is_clear    = cmd_q == CMD_CLEAR;
  assign stat_o.scan_done   = !issue && !rdv_q;
  assign stat_o.cls         = cls_c;
  assign stat_o.absorb_done = !hit_any || iter_q == IterMax;
  assign stat_o.div_done    = div_done;

  // Result fields.
  assign status_o          = class_q;
  assign ack_seq_o         = exp_w_q;
  assign nack_o            = nack_q;
  assign nack_seq_o        = (class_q == ST_OOO) ? exp_w_q : 32'd0;
  assign nack_size_o       = (class_q == ST_OOO) ? step : 16'd0;
  assign gap_o             = gap_q;
  assign rtt_min_o         = has_win ? {lo_q, 1'b0} : 33'd0;
  assign rtt_max_o         = has_win ? {hi_q, 1'b0} : 33'd0;
  assign delay_spread_o    = has_win ? spread : 32'd0;
  assign buffer_overflow_o = ovf_q;

endmodule

[hw/rtl/rnt_ctrl.sv]
// ----------------------------------------------------------------------------
// RDMA receiver tracker controller
// Sequences the datapath through sampling, scanning, reordering and NACK test.
// ----------------------------------------------------------------------------
module rnt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output logic                res_valid_o,
  output rnt_pkg::ctl_cmd_t   ctl_o,
  input  rnt_pkg::dp_status_t stat_i
);
  import rnt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SAMPLE = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_ABSORB = 9'b000001000,
    S_DIV    = 9'b000010000,
    S_GAP    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_CMP    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.cap = 1'b1;
          state_d   = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        if (stat_i.is_clear) begin
          ctl_o.clear = 1'b1;
          state_d     = S_OUT;
        end else begin
          ctl_o.sample = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          ctl_o.classify = 1'b1;
          case (stat_i.cls)
            ST_DUP: state_d = S_OUT;
            ST_INORD: begin
              ctl_o.adv = 1'b1;
              state_d   = S_ABSORB;
            end
            default: begin
              ctl_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          endcase
        end
      end
      S_ABSORB: begin
        ctl_o.absorb = 1'b1;
        if (stat_i.absorb_done) begin
          ctl_o.commit = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        ctl_o.store = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        ctl_o.cmp = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = state_q == S_OUT;

endmodule

[hw/rtl/rdma_receiver_ack_nack_tracker.sv]
// ----------------------------------------------------------------------------
// RDMA receiver ACK/NACK tracker
// Per-flow reorder tracking, delay window statistics and NACK generation.
// ----------------------------------------------------------------------------
// Usage: a transaction is accepted on a rising edge with start high and busy
// low; the fields cmd_i, flow_i, seq_i, size_i, packet_size_i and delay_ns_i
// are sampled at that edge. Exactly one result follows: its fields are valid
// for the single cycle in which res_valid_o is high. The receiver cannot hold
// results off, and busy stays high until the result cycle has ended.
// Sequence: a clear goes straight to its result. Any other transaction first
// reads its flow's held delay samples one per cycle from the sample RAM (none
// with fewer than two samples, else up to 16). An in-order packet then absorbs
// the buffered segments that now line up, at most PENDING_SLOTS of them. An
// out-of-order packet runs the 32-step bit-serial divider that yields both
// PSNs, then the slot store and the two-stage multiply and compare.
// Configuration writes via cfg_we_i, cfg_idx_i and cfg_wdata_i take effect
// at once; the user must make them only while the block is idle, as the block
// itself does not enforce it. Reset empties every flow and restores
// window_size to 16 and bandwidth_q8 to 25600.
// ----------------------------------------------------------------------------
module rdma_receiver_ack_nack_tracker #(
  parameter int unsigned PENDING_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [3:0]  flow_i,
  input  logic [31:0] seq_i,
  input  logic [15:0] size_i,
  input  logic [15:0] packet_size_i,
  input  logic [31:0] delay_ns_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  output logic        res_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] ack_seq_o,
  output logic        nack_o,
  output logic [31:0] nack_seq_o,
  output logic [15:0] nack_size_o,
  output logic [31:0] gap_o,
  output logic [32:0] rtt_min_o,
  output logic [32:0] rtt_max_o,
  output logic [31:0] delay_spread_o,
  output logic        buffer_overflow_o
);
  import rnt_pkg::*;

  `include "rdma_receiver_ack_nack_tracker_assert.svh"

  ctl_cmd_t   ctl;
  dp_status_t stat;

  // Controller.
  rnt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .res_valid_o,
    .ctl_o (ctl),
    .stat_i(stat)
  );

  // Datapath.
  rnt_dp #(.PendingSlots(PENDING_SLOTS)) u_dp (
    .clk_i,
    .rst_ni,
    .ctl_i (ctl),
    .stat_o(stat),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cmd_i,
    .flow_i,
    .seq_i,
    .size_i,
    .packet_size_i,
    .delay_ns_i,
    .status_o,
    .ack_seq_o,
    .nack_o,
    .nack_seq_o,
    .nack_size_o,
    .gap_o,
    .rtt_min_o,
    .rtt_max_o,
    .delay_spread_o,
    .buffer_overflow_o
  );

  // Checks on the transaction sequencing and result contents.
  `RNT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted transaction did not raise busy")
  `RNT_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, res_valid_o, !res_valid_o && !busy, "result strobe longer than one cycle")
  `RNT_ASSERT_SAME(a_clear_zero, clk_i, rst_ni, res_valid_o && status_o == ST_CLEAR, ack_seq_o == 32'd0 && !nack_o && rtt_max_o == 33'd0, "clear result not zero")
  `RNT_ASSERT_SAME(a_inorder_fields, clk_i, rst_ni, res_valid_o && status_o != ST_OOO, gap_o == 32'd0 && !nack_o && !buffer_overflow_o, "out-of-order fields set on other result")

endmodule

[tb/rdma_receiver_ack_nack_tracker_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RDMA receiver ACK/NACK tracker checker
// Watches the command, configuration and result ports, predicts each result
// from its own copy of the per-flow state and compares field by field.
// ----------------------------------------------------------------------------
module rdma_receiver_ack_nack_tracker_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        cmd_i,
  input  logic [3:0]  flow_i,
  input  logic [31:0] seq_i,
  input  logic [15:0] size_i,
  input  logic [15:0] packet_size_i,
  input  logic [31:0] delay_ns_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        res_valid_o,
  input  logic [1:0]  status_o,
  input  logic [31:0] ack_seq_o,
  input  logic        nack_o,
  input  logic [31:0] nack_seq_o,
  input  logic [15:0] nack_size_o,
  input  logic [31:0] gap_o,
  input  logic [32:0] rtt_min_o,
  input  logic [32:0] rtt_max_o,
  input  logic [31:0] delay_spread_o,
  input  logic        buffer_overflow_o,
  output int          errors_o,
  output int          outstanding_o,
  output int          nacks_seen_o,
  output int          overflows_seen_o
);
  import rnt_pkg::*;

  localparam int Slots     = 8;
  localparam int FifoDepth = 4;

  typedef struct packed {
    pkt_status_e status;
    logic [31:0] ack_seq;
    logic        nack;
    logic [31:0] nack_seq;
    logic [15:0] nack_size;
    logic [31:0] gap;
    logic [32:0] rtt_min;
    logic [32:0] rtt_max;
    logic [31:0] spread;
    logic        overflow;
  } ack_result_t;

  // Shadow copy of the tracker state.
  logic [4:0]  win_cfg;
  logic [19:0] bw_cfg;
  logic [31:0] next_seq    [Flows];
  logic [31:0] delay_ring  [Flows][WindowMax];
  logic [4:0]  ring_count  [Flows];
  logic [3:0]  ring_head   [Flows];
  logic        seg_valid   [Flows][Slots];
  logic [31:0] seg_seq     [Flows][Slots];
  logic [15:0] seg_size    [Flows][Slots];

  // Predicted results waiting for the block, oldest first.
  ack_result_t exp_fifo [FifoDepth];
  int          fifo_wr;
  int          fifo_rd;
  int          fifo_cnt;

  assign outstanding_o = fifo_cnt;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors_o++;
  endtask

  task automatic clear_tracker();
    win_cfg = WinReset;
    bw_cfg  = BwReset;
    for (int f = 0; f < Flows; f++) begin
      next_seq[f] = '0;
      ring_count[f] = '0;
      ring_head[f] = '0;
      for (int k = 0; k < Slots; k++) seg_valid[f][k] = 1'b0;
    end
  endtask

  // Computes the result of one accepted transaction and updates the shadow.
  task automatic track_packet(output ack_result_t r);
    int          f;
    int          hit;
    logic [4:0]  w;
    logic [31:0] lo, hi, v, stp, expv, epsn, psn;
    logic        has_win;
    r = '0;
    f = flow_i;
    if (cmd_i == CMD_CLEAR) begin
      next_seq[f] = '0;
      ring_count[f] = '0;
      ring_head[f] = '0;
      for (int k = 0; k < Slots; k++) seg_valid[f][k] = 1'b0;
      r.status = ST_CLEAR;
      return;
    end
    // A non-zero delay enters the ring; a shrunken window trims it here.
    if (delay_ns_i != 0) begin
      w = (win_cfg < 1) ? 5'd1 : ((win_cfg > WindowMax) ? 5'(WindowMax) : win_cfg);
      delay_ring[f][ring_head[f]] = delay_ns_i;
      ring_head[f] = ring_head[f] + 4'd1;
      if (ring_count[f] < WindowMax) ring_count[f]++;
      if (ring_count[f] > w) ring_count[f] = w;
    end
    has_win = ring_count[f] >= 2;
    if (has_win) begin
      lo = '1;
      hi = '0;
      for (int k = 0; k < ring_count[f]; k++) begin
        v = delay_ring[f][4'(ring_head[f] - 4'd1 - 4'(k))];
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      r.rtt_min = {lo, 1'b0};
      r.rtt_max = {hi, 1'b0};
      r.spread  = hi - lo;
    end
    stp  = (packet_size_i != 0) ? packet_size_i : ((size_i > 1) ? size_i : 32'd1);
    expv = next_seq[f];
    if (seq_i < expv) begin
      r.status = ST_DUP;
    end else if (seq_i == expv) begin
      // Advance, then absorb buffered segments that now line up.
      r.status = ST_INORD;
      expv = expv + size_i;
      for (int n = 0; n < Slots; n++) begin
        hit = -1;
        for (int k = Slots - 1; k >= 0; k--)
          if (seg_valid[f][k] && seg_seq[f][k] == expv) hit = k;
        if (hit < 0) break;
        seg_valid[f][hit] = 1'b0;
        expv = expv + seg_size[f][hit];
      end
      next_seq[f] = expv;
    end else begin
      r.status = ST_OOO;
      epsn = expv / stp;
      psn  = seq_i / stp;
      r.gap = (psn > epsn) ? psn - epsn : '0;
      hit = -1;
      for (int k = Slots - 1; k >= 0; k--)
        if (seg_valid[f][k] && seg_seq[f][k] == seq_i) hit = k;
      if (hit < 0)
        for (int k = Slots - 1; k >= 0; k--)
          if (!seg_valid[f][k]) hit = k;
      if (hit < 0) begin
        r.overflow = 1'b1;
      end else begin
        seg_valid[f][hit] = 1'b1;
        seg_seq[f][hit] = seq_i;
        seg_size[f][hit] = size_i;
      end
      if (has_win && (64'(r.gap) * 64'(stp) * 64'd2048 > 64'(r.spread) * 64'(bw_cfg)))
        r.nack = 1'b1;
      r.nack_seq  = expv;
      r.nack_size = stp[15:0];
    end
    r.ack_seq = expv;
  endtask

  // Sample on every edge: configuration, results, then new transactions.
  always @(posedge clk_i) begin
    ack_result_t want, got;
    if (!rst_ni) begin
      clear_tracker();
      fifo_wr = 0;
      fifo_rd = 0;
      fifo_cnt = 0;
      errors_o = 0;
      nacks_seen_o = 0;
      overflows_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WINDOW_SIZE) win_cfg = cfg_wdata_i[4:0];
        else bw_cfg = cfg_wdata_i;
      end
      if (res_valid_o) begin
        got = '{pkt_status_e'(status_o), ack_seq_o, nack_o, nack_seq_o, nack_size_o, gap_o,
                rtt_min_o, rtt_max_o, delay_spread_o, buffer_overflow_o};
        if (got.nack) nacks_seen_o++;
        if (got.overflow) overflows_seen_o++;
        if (fifo_cnt == 0) begin
          $display("%0t: result with no transaction outstanding", $realtime);
          errors_o++;
        end else begin
          want = exp_fifo[fifo_rd];
          fifo_rd = (fifo_rd + 1) % FifoDepth;
          fifo_cnt--;
          if (got.status != want.status)       report_mismatch("status", got.status, want.status);
          if (got.ack_seq != want.ack_seq)     report_mismatch("ack_seq", got.ack_seq, want.ack_seq);
          if (got.nack != want.nack)           report_mismatch("nack", got.nack, want.nack);
          if (got.nack_seq != want.nack_seq)   report_mismatch("nack_seq", got.nack_seq,
                                                               want.nack_seq);
          if (got.nack_size != want.nack_size) report_mismatch("nack_size", got.nack_size,
                                                               want.nack_size);
          if (got.gap != want.gap)             report_mismatch("gap", got.gap, want.gap);
          if (got.rtt_min != want.rtt_min)     report_mismatch("rtt_min", got.rtt_min,
                                                               want.rtt_min);
          if (got.rtt_max != want.rtt_max)     report_mismatch("rtt_max", got.rtt_max,
                                                               want.rtt_max);
          if (got.spread != want.spread)       report_mismatch("delay_spread", got.spread,
                                                               want.spread);
          if (got.overflow != want.overflow)   report_mismatch("buffer_overflow", got.overflow,
                                                               want.overflow);
        end
      end
      if (start && !busy) begin
        track_packet(want);
        if (fifo_cnt == FifoDepth) begin
          $display("%0t: too many transactions outstanding", $realtime);
          errors_o++;
        end else begin
          exp_fifo[fifo_wr] = want;
          fifo_wr = (fifo_wr + 1) % FifoDepth;
          fifo_cnt++;
        end
      end
    end
  end

endmodule

[tb/rdma_receiver_ack_nack_tracker_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RDMA receiver ACK/NACK tracker testbench
// Drives directed and random packet streams over several configurations and
// idle patterns; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module rdma_receiver_ack_nack_tracker_tb;
  import rnt_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = CMD_DATA;
  logic [3:0]  flow_i = '0;
  logic [31:0] seq_i = '0;
  logic [15:0] size_i = '0;
  logic [15:0] packet_size_i = '0;
  logic [31:0] delay_ns_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_WINDOW_SIZE;
  logic [19:0] cfg_wdata_i = '0;
  logic        res_valid_o;
  logic [1:0]  status_o;
  logic [31:0] ack_seq_o;
  logic        nack_o;
  logic [31:0] nack_seq_o;
  logic [15:0] nack_size_o;
  logic [31:0] gap_o;
  logic [32:0] rtt_min_o;
  logic [32:0] rtt_max_o;
  logic [31:0] delay_spread_o;
  logic        buffer_overflow_o;
  int          errors, outstanding, nacks_seen, overflows_seen;

  int          cycles = 0;
  int          sent = 0;
  int          idle_pct = 0;

  // Stimulus bookkeeping: where each flow is believed to stand.
  logic [31:0] flow_next  [16];
  logic [15:0] flow_chunk [16];
  logic [7:0]  flow_held  [16];

  always #10 clk_i = ~clk_i;

  rdma_receiver_ack_nack_tracker dut (.*);

  rdma_receiver_ack_nack_tracker_checker checker_i (.*, .errors_o(errors),
    .outstanding_o(outstanding), .nacks_seen_o(nacks_seen),
    .overflows_seen_o(overflows_seen));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("** rdma_receiver_ack_nack_tracker: FAILED **");
      $finish;
    end
  end

  // Offers one transaction and returns at the edge that accepts it.
  task automatic send(input logic cmd, input logic [3:0] flow, input logic [31:0] seq,
                      input logic [15:0] size, input logic [15:0] psize,
                      input logic [31:0] delay);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    flow_i <= flow;
    seq_i <= seq;
    size_i <= size;
    packet_size_i <= psize;
    delay_ns_i <= delay;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  // Waits for every result, then writes one register.
  task automatic write_reg(input logic idx, input logic [19:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return $urandom();
    if (r < 18) return (r < 17) ? 32'd1 : 32'hFFFF_FFFF;
    return 32'd5000 + $urandom_range(3000);
  endfunction

  // Well-formed traffic on a flow: mostly in order or a few segments ahead.
  task automatic flow_packet(input logic [3:0] f);
    int          r, k;
    logic [15:0] ps;
    r = $urandom_range(99);
    ps = ($urandom_range(1)) ? 16'd0 : (($urandom_range(3) == 0) ? 16'($urandom()) :
                                                                   flow_chunk[f]);
    if (r < 5) begin
      send(CMD_CLEAR, f, $urandom(), 16'($urandom()), 16'($urandom()), $urandom());
      flow_next[f] = '0;
      flow_held[f] = '0;
      flow_chunk[f] = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 2000));
    end else if (r < 50) begin
      send(CMD_DATA, f, flow_next[f], flow_chunk[f], ps, pick_delay());
      flow_next[f] = flow_next[f] + flow_chunk[f];
      flow_held[f] = flow_held[f] >> 1;
      while (flow_held[f][0]) begin
        flow_held[f] = flow_held[f] >> 1;
        flow_next[f] = flow_next[f] + flow_chunk[f];
      end
    end else if (r < 75) begin
      k = $urandom_range(1, 6);
      send(CMD_DATA, f, flow_next[f] + k * flow_chunk[f], flow_chunk[f], ps, pick_delay());
      flow_held[f][k] = 1'b1;
    end else if (r < 85) begin
      send(CMD_DATA, f, (flow_next[f] != 0) ? flow_next[f] - $urandom_range(1, 100) :
           $urandom(), flow_chunk[f], ps, pick_delay());
    end else begin
      send(1'($urandom_range(1)), f, $urandom(), 16'($urandom()), 16'($urandom()),
           $urandom());
      flow_held[f] = '0;
    end
  endtask

  initial begin
    int pcts [6];
    logic [4:0]  wins [6];
    logic [19:0] bws  [6];
    pcts = '{0, 56, 33, 0, 56, 33};
    wins = '{5'd16, 5'd0, 5'd2, 5'd31, 5'd1, 5'd7};
    bws  = '{20'd25600, 20'd0, 20'hFFFFF, 20'd1, 20'd300, 20'd25600};
    for (int f = 0; f < 16; f++) begin
      flow_next[f] = '0;
      flow_held[f] = '0;
      flow_chunk[f] = 16'($urandom_range(1, 1500));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, duplicates, reordering, overflow and clear.
    send(CMD_DATA, 4'd0, 32'd0, 16'd100, 16'd0, 32'd1);
    send(CMD_DATA, 4'd0, 32'd100, 16'd0, 16'd0, 32'hFFFF_FFFF);
    send(CMD_DATA, 4'd0, 32'd50, 16'd10, 16'd0, 32'd0);
    send(CMD_DATA, 4'd0, 32'd300, 16'd100, 16'd100, 32'd7);
    send(CMD_DATA, 4'd0, 32'd300, 16'd200, 16'd100, 32'd9);
    send(CMD_DATA, 4'd0, 32'd200, 16'd100, 16'd100, 32'd8);
    send(CMD_DATA, 4'd0, 32'd100, 16'd100, 16'hFFFF, 32'd8);
    send(CMD_DATA, 4'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd3);
    send(CMD_DATA, 4'd1, 32'hFFFF_FFFF, 16'd1, 16'd1, 32'd1000);
    for (int k = 1; k <= 9; k++)
      send(CMD_DATA, 4'd3, 32'(k) * 32'd1000, 16'd1000, 16'd1000, 32'(k * 100));
    send(CMD_DATA, 4'd3, 32'd0, 16'd1000, 16'd0, 32'd0);
    send(CMD_CLEAR, 4'd3, 32'd0, 16'd0, 16'd0, 32'd0);
    send(CMD_DATA, 4'd15, 32'd0, 16'hFFFF, 16'd0, 32'd5);
    send(CMD_CLEAR, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(CMD_DATA, 4'd0, 32'd0, 16'd0, 16'd0, 32'd0);
    for (int f = 0; f < 16; f++) begin
      flow_next[f] = (f == 1 || f == 4'd15) ? flow_next[f] : '0;
      flow_held[f] = '0;
    end
    flow_next[1] = 32'd0;
    flow_next[15] = 32'hFFFF;
    flow_next[3] = 32'd1000;
    flow_held[3] = '0;

    // Random phases, each under its own configuration and idle pattern.
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_WINDOW_SIZE, {15'($urandom_range(32'h7FFF)), wins[p]});
      write_reg(REG_BANDWIDTH, bws[p]);
      idle_pct = pcts[p];
      for (int n = 0; n < 180; n++)
        flow_packet(($urandom_range(4) == 0) ? 4'($urandom()) : 4'($urandom_range(3)));
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d transactions over six settings of window and bandwidth,", sent);
    $display("with %0d NACKs and %0d buffer overflows observed.", nacks_seen, overflows_seen);
    if (errors == 0) begin
      $display("** rdma_receiver_ack_nack_tracker: PASSED **");
    end else begin
      $display("** rdma_receiver_ack_nack_tracker: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/rnt_pkg.sv
hw/rtl/rnt_ram.sv
hw/rtl/rnt_div.sv
hw/rtl/rnt_dp.sv
hw/rtl/rnt_ctrl.sv
hw/rtl/rdma_receiver_ack_nack_tracker.sv
tb/rdma_receiver_ack_nack_tracker_checker.sv
tb/rdma_receiver_ack_nack_tracker_tb.sv
